/* design/sbps_pkg.sv */
// Shared types, constants and the band damping table for the spectrum bar pixel shader.
// Stands alone; the top level takes everything here by scoped names.
`default_nettype none

package sbps_pkg;

   // Default values of the top-level parameters.
   localparam int BANDS_DEF    = 16;
   localparam int MAX_LEDS_DEF = 1024;

   // Field widths.
   localparam int LED_CNT_W  = 11;
   localparam int LED_IDX_W  = 10;
   localparam int BAND_IDX_W = 4;
   localparam int LEVEL_W    = 8;
   localparam int COEF_W     = 9;
   localparam int COLOR_W    = 8;
   localparam int GAIN_W     = 9;
   localparam int GAIN_SEL_W = 8;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LED_COUNT   = 1'b0;
   localparam logic REG_TRANS_COLOR = 1'b1;
   localparam logic [LED_CNT_W-1:0] LED_COUNT_RST = 11'd60;

   // Request kinds and transition targets.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;
   localparam logic TC_WHITE   = 1'b0;
   localparam logic TC_BLACK   = 1'b1;

   // Q8 damping gains.
   localparam logic [GAIN_W-1:0] GAIN_BASS  = 9'd333;
   localparam logic [GAIN_W-1:0] GAIN_LOW   = 9'd282;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;
   localparam logic [GAIN_W-1:0] GAIN_MID   = 9'd230;

   // Arithmetic constants.
   localparam logic [COEF_W-1:0] Q8_ONE = 9'd256;
   localparam int HUE_SCALE = 160;
   localparam int VAL_BASE  = 40;
   localparam int VAL_SPAN  = 215;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DIV   = 9'b000000010,
      S_RD0   = 9'b000000100,
      S_RD1   = 9'b000001000,
      S_MUL0  = 9'b000010000,
      S_MUL1  = 9'b000100000,
      S_SCALE = 9'b001000000,
      S_VAL   = 9'b010000000,
      S_MIX   = 9'b100000000
   } state_type;

   // Per-band damping gain; bands not listed in the table run at unity.
   function automatic logic [GAIN_W-1:0] damp_gain(input logic [GAIN_SEL_W-1:0] band);
      logic [GAIN_W-1:0] g;
      case (band)
         8'd0, 8'd1: begin
            g = GAIN_BASS;
         end
         8'd2: begin
            g = GAIN_LOW;
         end
         8'd5, 8'd6, 8'd8, 8'd9, 8'd10: begin
            g = GAIN_MID;
         end
         default: begin
            g = GAIN_UNITY;
         end
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* design/spectrum_bar_pixel_shader.sv */
// Render requests are taken one at a time: after acceptance, a bit-serial divider by the LED count
// runs over a dividend of DW = clog2(BANDS) + 18 bits, then states S_RD0 to S_MIX follow; requests
// are stalled until the block is back in idle, and S_MIX holds while the response is stalled.
// Load requests write the band store in the cycle of acceptance, one per cycle while idle.
// Synchronous active-high reset: all band levels read as zero, led_count = 60,
// transition_color = white. Depends on sbps_pkg.
`default_nettype none

module spectrum_bar_pixel_shader #(
   parameter int BANDS    = sbps_pkg::BANDS_DEF,
   parameter int MAX_LEDS = sbps_pkg::MAX_LEDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic [sbps_pkg::BAND_IDX_W-1:0]   req_band_index,
   input  wire logic [sbps_pkg::LEVEL_W-1:0]      req_band_power,
   input  wire logic [sbps_pkg::LED_IDX_W-1:0]    req_led_index,
   input  wire logic                              req_transition_on,
   input  wire logic [sbps_pkg::COEF_W-1:0]       req_blend_coef,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [sbps_pkg::LED_IDX_W-1:0]         rsp_pixel_index,
   output logic [sbps_pkg::COLOR_W-1:0]           rsp_hue,
   output logic [sbps_pkg::COLOR_W-1:0]           rsp_saturation,
   output logic [sbps_pkg::COLOR_W-1:0]           rsp_brightness,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sbps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [sbps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sbps_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   // Band address width, the product width of (BANDS-1)*led and the dividend width.
   // Both dividends (160*led and (BANDS-1)*led*256) fit in DW bits.
   localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int PW    = BW + 10;
   localparam int DW    = PW + 8;
   localparam int CNT_W = $clog2(DW);
   localparam int LCW   = sbps_pkg::LED_CNT_W;
   // Largest LED count that the divider ever sees.
   localparam int N_CAP = (MAX_LEDS > 2047) ? 2047 : MAX_LEDS;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   sbps_pkg::state_type state_ff, state_in;

   logic [LCW-1:0]                     led_count_ff, led_count_in;
   logic                               trans_color_ff, trans_color_in;

   logic [sbps_pkg::LED_IDX_W-1:0]     led_ff, led_in;
   logic [sbps_pkg::COEF_W-1:0]        coef_ff, coef_in;
   logic                               trans_on_ff, trans_on_in;

   // Divider: two lanes share one counter, the divisor and the step timing.
   logic [LCW-1:0]                     div_n_ff, div_n_in;
   logic [DW-1:0]                      dvd_h_ff, dvd_h_in;
   logic [DW-1:0]                      dvd_p_ff, dvd_p_in;
   logic [LCW-1:0]                     rem_h_ff, rem_h_in;
   logic [LCW-1:0]                     rem_p_ff, rem_p_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;

   logic [BW-1:0]                      lo_ff, lo_in;
   logic [BW-1:0]                      hi_ff, hi_in;
   logic [7:0]                         frac_ff, frac_in;
   logic [sbps_pkg::COLOR_W-1:0]       hue_ff, hue_in;

   logic [16:0]                        gprod_ff, gprod_in;
   logic [15:0]                        acc_ff, acc_in;
   logic [23:0]                        scaled_ff, scaled_in;
   logic [sbps_pkg::COLOR_W-1:0]       val_ff, val_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sbps_pkg::LED_IDX_W-1:0]     out_idx_ff, out_idx_in;
   logic [sbps_pkg::COLOR_W-1:0]       out_hue_ff, out_hue_in;
   logic [sbps_pkg::COLOR_W-1:0]       out_sat_ff, out_sat_in;
   logic [sbps_pkg::COLOR_W-1:0]       out_bri_ff, out_bri_in;

   // Band store: a synchronous memory plus one valid bit per band. An entry whose
   // valid bit is clear reads as level zero, so reset needs no clearing pass.
   logic [sbps_pkg::LEVEL_W-1:0]       band_mem [BANDS];
   logic [BANDS-1:0]                   band_vld_ff;
   logic [sbps_pkg::LEVEL_W-1:0]       mem_q_ff;
   logic                               vld_q_ff;

   // ------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------
   logic                               req_accept;
   logic                               load_accept;
   logic                               render_accept;
   logic                               csr_write;
   logic [BW-1:0]                      wr_band;
   logic [BW-1:0]                      rd_addr;
   logic [LCW-1:0]                     n_eff;
   logic [17:0]                        hue_num;
   logic [PW-1:0]                      pos_prod;
   logic [LCW:0]                       step_h, step_p;
   logic                               ge_h, ge_p;
   logic [PW-1:0]                      lo_full;
   logic [BW-1:0]                      lo_c, hi_c;
   logic [7:0]                         frac_c;
   logic [sbps_pkg::LEVEL_W-1:0]       level;
   logic [BW-1:0]                      gain_band;
   logic [sbps_pkg::GAIN_W-1:0]        gain;
   logic [sbps_pkg::LEVEL_W-1:0]       damped;
   logic [8:0]                         weight;
   logic [16:0]                        wprod;
   logic [16:0]                        acc_sum;
   logic [15:0]                        val_y;
   logic [16:0]                        val_t;
   logic [8:0]                         val_q;
   logic [8:0]                         inv_coef;
   logic [16:0]                        mix_cv;
   logic [16:0]                        mix_white;
   logic [16:0]                        mix_sat;
   logic                               out_free;

   // Band index reduced modulo BANDS: four conditional subtractions of BANDS*8,
   // BANDS*4, BANDS*2 and BANDS cover every 4-bit index.
   function automatic logic [BW-1:0] wrap_band(input logic [sbps_pkg::BAND_IDX_W-1:0] idx);
      logic [10:0] r;
      r = 11'(idx);
      for (int k = 3; k >= 0; k--) begin
         if (r >= 11'(BANDS << k)) begin
            r = r - 11'(BANDS << k);
         end
      end
      return BW'(r);
   endfunction

   assign req_accept    = req_valid && !req_stall;
   assign load_accept   = req_accept && (req_type == sbps_pkg::REQ_LOAD);
   assign render_accept = req_accept && (req_type == sbps_pkg::REQ_RENDER);
   assign wr_band       = wrap_band(req_band_index);

   // The block works on one render request at a time; loads only come in while idle.
   assign req_stall  = (state_ff != sbps_pkg::S_IDLE);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         sbps_pkg::REG_LED_COUNT: begin
            csr_prdata = sbps_pkg::CSR_DATA_W'(led_count_ff);
         end
         default: begin
            csr_prdata = sbps_pkg::CSR_DATA_W'(trans_color_ff);
         end
      endcase
   end

   // LED count as the divisor: capped at MAX_LEDS, and a count of zero acts as one.
   always_comb begin
      if (led_count_ff > LCW'(N_CAP)) begin
         n_eff = LCW'(N_CAP);
      end else if (led_count_ff == '0) begin
         n_eff = LCW'(1);
      end else begin
         n_eff = led_count_ff;
      end
   end

   assign hue_num  = 18'({8'd0, req_led_index} * 18'(sbps_pkg::HUE_SCALE));
   assign pos_prod = PW'(PW'(req_led_index) * PW'(BANDS - 1));

   // One restoring-division step per cycle in each lane.
   assign step_h = {rem_h_ff, dvd_h_ff[DW-1]};
   assign step_p = {rem_p_ff, dvd_p_ff[DW-1]};
   assign ge_h   = step_h >= {1'b0, div_n_ff};
   assign ge_p   = step_p >= {1'b0, div_n_ff};

   // Band position split: lower band, upper band and Q8 fraction. At or past the
   // last band both neighbors are the last band with a zero fraction.
   assign lo_full = dvd_p_ff[DW-1:8];
   always_comb begin
      if (lo_full >= PW'(BANDS - 1)) begin
         lo_c   = BW'(BANDS - 1);
         hi_c   = BW'(BANDS - 1);
         frac_c = 8'd0;
      end else begin
         lo_c   = BW'(lo_full);
         hi_c   = BW'(lo_full + PW'(1));
         frac_c = dvd_p_ff[7:0];
      end
   end

   assign rd_addr = (state_ff == sbps_pkg::S_RD0) ? lo_c : hi_ff;

   // Damped level of the band read last cycle, and the blend weight.
   assign level     = vld_q_ff ? mem_q_ff : '0;
   assign gain_band = (state_ff == sbps_pkg::S_RD1) ? lo_ff : hi_ff;
   assign gain      = sbps_pkg::damp_gain(sbps_pkg::GAIN_SEL_W'(gain_band));
   assign damped    = gprod_ff[16] ? 8'hFF : gprod_ff[15:8];
   assign weight    = (state_ff == sbps_pkg::S_MUL0) ?
                      (sbps_pkg::Q8_ONE - {1'b0, frac_ff}) : {1'b0, frac_ff};
   assign wprod     = {8'd0, weight} * {9'd0, damped};
   assign acc_sum   = {1'b0, acc_ff} + wprod;

   // Division by 255*256: drop the low byte, then y/255 = (y + (y >> 8) + 1) >> 8,
   // which is exact for every 16-bit y but 65535, a value that y never reaches here.
   assign val_y = scaled_ff[23:8];
   assign val_t = {1'b0, val_y} + {9'd0, val_y[15:8]} + 17'd1;
   assign val_q = val_t[16:8];

   // Transition blend. (256-c)*255 and 255*c are shift-and-subtract forms.
   assign inv_coef  = sbps_pkg::Q8_ONE - coef_ff;
   assign mix_cv    = {8'd0, coef_ff} * {9'd0, val_ff};
   assign mix_white = {inv_coef, 8'd0} - {8'd0, inv_coef};
   assign mix_sat   = {coef_ff, 8'd0} - {8'd0, coef_ff};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      logic [16:0] bri_sum;

      state_in       = state_ff;
      led_count_in   = led_count_ff;
      trans_color_in = trans_color_ff;
      led_in         = led_ff;
      coef_in        = coef_ff;
      trans_on_in    = trans_on_ff;
      div_n_in       = div_n_ff;
      dvd_h_in       = dvd_h_ff;
      dvd_p_in       = dvd_p_ff;
      rem_h_in       = rem_h_ff;
      rem_p_in       = rem_p_ff;
      cnt_in         = cnt_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      frac_in        = frac_ff;
      hue_in         = hue_ff;
      gprod_in       = gprod_ff;
      acc_in         = acc_ff;
      scaled_in      = scaled_ff;
      val_in         = val_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_idx_in     = out_idx_ff;
      out_hue_in     = out_hue_ff;
      out_sat_in     = out_sat_ff;
      out_bri_in     = out_bri_ff;
      bri_sum        = mix_cv + mix_white;

      if (csr_write) begin
         case (csr_paddr[2])
            sbps_pkg::REG_LED_COUNT: begin
               led_count_in = csr_pwdata[LCW-1:0];
            end
            default: begin
               trans_color_in = csr_pwdata[0];
            end
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sbps_pkg::S_IDLE: begin
            if (render_accept) begin
               led_in      = req_led_index;
               coef_in     = (req_blend_coef > sbps_pkg::Q8_ONE) ?
                             sbps_pkg::Q8_ONE : req_blend_coef;
               trans_on_in = req_transition_on;
               div_n_in    = n_eff;
               dvd_h_in    = DW'(hue_num);
               dvd_p_in    = {pos_prod, 8'd0};
               rem_h_in    = '0;
               rem_p_in    = '0;
               cnt_in      = CNT_W'(DW - 1);
               state_in    = sbps_pkg::S_DIV;
            end
         end
         sbps_pkg::S_DIV: begin
            rem_h_in = ge_h ? LCW'(step_h - {1'b0, div_n_ff}) : step_h[LCW-1:0];
            rem_p_in = ge_p ? LCW'(step_p - {1'b0, div_n_ff}) : step_p[LCW-1:0];
            dvd_h_in = {dvd_h_ff[DW-2:0], ge_h};
            dvd_p_in = {dvd_p_ff[DW-2:0], ge_p};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = sbps_pkg::S_RD0;
            end
         end
         sbps_pkg::S_RD0: begin
            // Lower band is being read; latch the split and the saturated hue.
            lo_in    = lo_c;
            hi_in    = hi_c;
            frac_in  = frac_c;
            hue_in   = (|dvd_h_ff[DW-1:8]) ? 8'hFF : dvd_h_ff[7:0];
            state_in = sbps_pkg::S_RD1;
         end
         sbps_pkg::S_RD1: begin
            gprod_in = {9'd0, level} * {8'd0, gain};
            state_in = sbps_pkg::S_MUL0;
         end
         sbps_pkg::S_MUL0: begin
            gprod_in = {9'd0, level} * {8'd0, gain};
            acc_in   = wprod[15:0];
            state_in = sbps_pkg::S_MUL1;
         end
         sbps_pkg::S_MUL1: begin
            acc_in   = acc_sum[15:0];
            state_in = sbps_pkg::S_SCALE;
         end
         sbps_pkg::S_SCALE: begin
            scaled_in = 24'({8'd0, acc_ff} * 24'(sbps_pkg::VAL_SPAN));
            state_in  = sbps_pkg::S_VAL;
         end
         sbps_pkg::S_VAL: begin
            val_in   = 8'(9'(sbps_pkg::VAL_BASE) + val_q);
            state_in = sbps_pkg::S_MIX;
         end
         sbps_pkg::S_MIX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_idx_in   = led_ff;
               out_hue_in   = hue_ff;
               out_sat_in   = 8'hFF;
               out_bri_in   = val_ff;
               if (trans_on_ff) begin
                  if (trans_color_ff == sbps_pkg::TC_WHITE) begin
                     out_bri_in = bri_sum[15:8];
                     out_sat_in = mix_sat[15:8];
                  end else begin
                     out_bri_in = mix_cv[15:8];
                  end
               end
               state_in = sbps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sbps_pkg::S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Band store
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_accept) begin
         band_mem[wr_band] <= req_band_power;
      end
      mem_q_ff <= band_mem[rd_addr];
      vld_q_ff <= band_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_vld_ff <= '0;
      end else if (load_accept) begin
         band_vld_ff[wr_band] <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Register update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sbps_pkg::S_IDLE;
         led_count_ff   <= sbps_pkg::LED_COUNT_RST;
         trans_color_ff <= sbps_pkg::TC_WHITE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         led_count_ff   <= led_count_in;
         trans_color_ff <= trans_color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      led_ff      <= led_in;
      coef_ff     <= coef_in;
      trans_on_ff <= trans_on_in;
      div_n_ff    <= div_n_in;
      dvd_h_ff    <= dvd_h_in;
      dvd_p_ff    <= dvd_p_in;
      rem_h_ff    <= rem_h_in;
      rem_p_ff    <= rem_p_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      frac_ff     <= frac_in;
      hue_ff      <= hue_in;
      gprod_ff    <= gprod_in;
      acc_ff      <= acc_in;
      scaled_ff   <= scaled_in;
      val_ff      <= val_in;
      out_idx_ff  <= out_idx_in;
      out_hue_ff  <= out_hue_in;
      out_sat_ff  <= out_sat_in;
      out_bri_ff  <= out_bri_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = out_idx_ff;
   assign rsp_hue         = out_hue_ff;
   assign rsp_saturation  = out_sat_ff;
   assign rsp_brightness  = out_bri_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // The divider's partial remainders never reach the divisor.
   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbps_pkg::S_DIV) |-> (rem_h_ff < div_n_ff) && (rem_p_ff < div_n_ff))
      else $error("divider remainder out of range");

   // The two neighbor bands are in the store and at most one apart.
   a_band_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbps_pkg::S_RD1) |->
         (hi_ff <= BW'(BANDS - 1)) &&
         ((hi_ff == lo_ff) || (hi_ff == BW'(lo_ff + 1'b1))))
      else $error("band pair out of range");

   // A result appears only as the last step of a render.
   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sbps_pkg::S_MIX))
      else $error("result without a finished render");

   // The interpolated value never drops below its base.
   a_val_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbps_pkg::S_MIX) |-> (val_ff >= 8'(sbps_pkg::VAL_BASE)))
      else $error("value below base");

endmodule

`default_nettype wire
